// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and character codes for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

endpackage

// ===== rtl/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a serial byte stream into '$'-prefixed, comma-separated command lines.
// ----------------------------------------------------------------------------
// One byte per cycle, back to back: a request is held in an input register and
// resolved against the line state by a few counter compares, with the outcome
// written to a result register. Token characters come out as they arrive
// (kind char), and a CR or LF closes the line with kind accept and the argument
// count, or kind reject. Bytes that produce nothing (empty line terminators,
// overflow bytes, dropped characters) still pass through the input register.
// Output stall backs up through the result register into in_stall.
module command_line_tokenizer #(
  parameter int LINE_MAX  = 64,
  parameter int MAX_ARGS  = 4,
  parameter int TOKEN_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [2:0] token_index,
  output logic [3:0] char_pos,
  output logic [7:0] char_value,
  output logic [2:0] arg_count
);

  localparam int LW  = $clog2(LINE_MAX);
  localparam int TSW = $clog2(MAX_ARGS + 3);
  localparam int TLW = $clog2(TOKEN_MAX);

  localparam logic [LW-1:0]  LINE_LIMIT = LW'(LINE_MAX - 1);
  localparam logic [TSW-1:0] TS_CAP     = TSW'(MAX_ARGS + 2);
  localparam logic [TSW-1:0] TS_KEEP    = TSW'(MAX_ARGS + 1);
  localparam logic [TSW-1:0] ARGS_MAX   = TSW'(MAX_ARGS);
  localparam logic [TLW-1:0] TL_LIMIT   = TLW'(TOKEN_MAX - 1);

  // input register
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;

  // line state
  logic [LW-1:0]  line_length, line_length_next;
  logic           line_bad, line_bad_next;
  logic           zero_seen, zero_seen_next;
  logic           in_token, in_token_next;
  logic [TSW-1:0] tokens_seen, tokens_seen_next;
  logic [TLW-1:0] token_length, token_length_next;

  // result computation
  logic           res_hit;
  logic [1:0]     res_kind;
  logic [2:0]     res_index;
  logic [3:0]     res_pos;
  logic [7:0]     res_char;
  logic [2:0]     res_args;
  logic [TSW-1:0] ts_work, ts_m1, args_clamped;
  logic [TLW-1:0] tl_work;
  logic [31:0]    ts_m1_wide, tl_wide, args_wide;
  logic           is_term;

  logic advance;
  logic process;

  assign advance  = !out_valid || !out_stall;
  assign process  = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;
  assign is_term  = (in_reg_byte == clt_pkg::CHAR_CR) || (in_reg_byte == clt_pkg::CHAR_LF);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_reg_byte <= rx_byte;
    end
  end

  always_comb begin
    line_length_next  = line_length;
    line_bad_next     = line_bad;
    zero_seen_next    = zero_seen;
    in_token_next     = in_token;
    tokens_seen_next  = tokens_seen;
    token_length_next = token_length;
    res_hit   = 1'b0;
    res_kind  = clt_pkg::KIND_CHAR;
    res_index = 3'd0;
    res_pos   = 4'd0;
    res_char  = 8'd0;
    res_args  = 3'd0;
    ts_work   = tokens_seen;
    tl_work   = token_length;
    ts_m1     = tokens_seen - TSW'(1);
    args_clamped = (ts_m1 > ARGS_MAX) ? ARGS_MAX : ts_m1;
    args_wide    = 32'(args_clamped);

    priority if (is_term) begin
      if (line_length != '0) begin
        res_hit = 1'b1;
        if (line_bad || tokens_seen == '0) begin
          res_kind = clt_pkg::KIND_REJECT;
        end else begin
          res_kind = clt_pkg::KIND_ACCEPT;
          res_args = args_wide[2:0];
        end
        line_length_next  = '0;
        line_bad_next     = 1'b0;
        zero_seen_next    = 1'b0;
        in_token_next     = 1'b0;
        tokens_seen_next  = '0;
        token_length_next = '0;
      end
    end else if (line_length < LINE_LIMIT) begin
      line_length_next = line_length + LW'(1);
      priority if (line_length == '0) begin
        if (in_reg_byte != clt_pkg::CHAR_DOLLAR) begin
          line_bad_next = 1'b1;
        end
      end else if (line_bad || zero_seen) begin
      end else if (in_reg_byte == clt_pkg::CHAR_NUL) begin
        zero_seen_next = 1'b1;
      end else if (in_reg_byte == clt_pkg::CHAR_COMMA) begin
        in_token_next = 1'b0;
      end else begin
        if (!in_token) begin
          in_token_next = 1'b1;
          if (tokens_seen < TS_CAP) begin
            ts_work = tokens_seen + TSW'(1);
          end
          tl_work = '0;
        end
        tokens_seen_next  = ts_work;
        token_length_next = tl_work;
        if (ts_work <= TS_KEEP && tl_work < TL_LIMIT) begin
          res_hit  = 1'b1;
          res_kind = clt_pkg::KIND_CHAR;
          res_char = in_reg_byte;
          token_length_next = tl_work + TLW'(1);
        end
      end
    end else begin
    end

    ts_m1_wide = 32'(ts_work - TSW'(1));
    tl_wide    = 32'(tl_work);
    if (res_hit && res_kind == clt_pkg::KIND_CHAR) begin
      res_index = ts_m1_wide[2:0];
      res_pos   = tl_wide[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      line_bad     <= 1'b0;
      zero_seen    <= 1'b0;
      in_token     <= 1'b0;
      tokens_seen  <= '0;
      token_length <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (process) begin
        line_length  <= line_length_next;
        line_bad     <= line_bad_next;
        zero_seen    <= zero_seen_next;
        in_token     <= in_token_next;
        tokens_seen  <= tokens_seen_next;
        token_length <= token_length_next;
      end
      if (advance) begin
        out_valid <= process && res_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process && res_hit) begin
      kind        <= res_kind;
      token_index <= res_index;
      char_pos    <= res_pos;
      char_value  <= res_char;
      arg_count   <= res_args;
    end
  end

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LINE_LIMIT)
    else $error("line length past limit");

  a_tokens_bound: assert property (@(posedge clk) disable iff (rst)
    tokens_seen <= TS_CAP)
    else $error("token count past cap");

  a_token_len_bound: assert property (@(posedge clk) disable iff (rst)
    token_length <= TL_LIMIT)
    else $error("token length past limit");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    process && is_term |=> line_length == '0 && tokens_seen == '0)
    else $error("terminator did not clear the line");

  a_bad_no_char: assert property (@(posedge clk) disable iff (rst)
    process && line_bad && !is_term |=> !(out_valid && $changed(char_value) &&
      kind == clt_pkg::KIND_CHAR) || $past(out_valid && out_stall))
    else $error("character reported on a rejected line");

endmodule
